@@ sv/snsd_pkg.sv @@
// Package for the stereo noise-shaped 24-bit dither block.
// Holds the fixed widths, generator seeds, tap weights and the xorshift step.
// No dependencies.
package snsd_pkg;

  localparam int IN_W         = 41;
  localparam int OUT_W        = 24;
  localparam int WORD_W       = 32;
  localparam int WEIGHT_W     = 18;
  localparam int PROD_W       = 50;
  localparam int PSUM_W       = 52;
  localparam int SUM_W        = 54;
  localparam int ZSUB_W       = 15;
  localparam int FRAC_W       = 16;
  localparam int HISTORY_TAPS = 8;
  localparam int GROUP_N      = 3;

  localparam logic [WORD_W-1:0] SEED_LEFT    = 32'h1234_5678;
  localparam logic [WORD_W-1:0] SEED_RIGHT   = 32'h8765_4321;
  localparam logic [ZSUB_W-1:0] ZERO_SUB_MUL = 15'd27862;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7F_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sh80_0000;

  // Q16 weights; entry 0 scales the live generator word, entry k history word k-1
  localparam logic signed [WEIGHT_W-1:0] TAP_WEIGHT [HISTORY_TAPS+1] = '{
    18'sd3998, -18'sd7209, 18'sd16384, -18'sd28180, 18'sd65536,
    -18'sd65536, 18'sd32768, -18'sd15073, 18'sd8258
  };

  // Pipeline control shared by all cells of a channel
  typedef struct packed {
    logic en;     // pipeline advances
    logic shift;  // a transaction is taken, state moves one place
  } snsd_ctl_t;

  // One xorshift32 step (13, 17, 5)
  function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage

@@ sv/snsd_if.sv @@
// Channel interfaces for the stereo dither block: input frames and results.
// Depends on snsd_pkg for field widths.
interface snsd_in_if import snsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  left_sample;
  logic signed [IN_W-1:0]  right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface snsd_out_if import snsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ sv/snsd_rng_cell.sv @@
// Head cell of the chain: xorshift32 generator, its weighted term and the
// zero-input substitute value. Depends on snsd_pkg.
module snsd_rng_cell import snsd_pkg::*; #(
  parameter logic [31:0] SEED = 32'h0000_0001
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  snsd_ctl_t                ctl,
  output logic [WORD_W-1:0]        word_o,
  output logic signed [PROD_W-1:0] prod_o,
  output logic [ZSUB_W-1:0]        zsub_o
);

  logic [WORD_W-1:0]        rng_r;
  logic [WORD_W-1:0]        rng_nxt;
  logic signed [PROD_W:0]   prod_full;
  logic [WORD_W+ZSUB_W-1:0] zsub_full;
  logic signed [PROD_W-1:0] prod_r;

  // generator advances once per transaction
  assign rng_nxt = ctl.shift ? xorshift_step(rng_r) : rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= SEED;
    end else begin
      rng_r <= rng_nxt;
    end
  end

  // term 0 and substitute, taken from the word in use at the transaction
  assign prod_full = $signed({1'b0, rng_r}) * TAP_WEIGHT[0];
  assign zsub_full = rng_r * ZERO_SUB_MUL;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
  end

  assign word_o = rng_r;
  assign prod_o = prod_r;
  // substitute goes out unregistered: it is muxed into the sample stage at the
  // same edge that takes the transaction
  assign zsub_o = zsub_full[WORD_W+ZSUB_W-1:WORD_W];

endmodule

@@ sv/snsd_cell.sv @@
// History cell: holds one past generator word, passes it on per transaction
// and registers its weighted term. Depends on snsd_pkg.
module snsd_cell import snsd_pkg::*; #(
  parameter logic signed [17:0] WEIGHT = 18'sd0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  snsd_ctl_t                ctl,
  input  logic [WORD_W-1:0]        word_i,
  output logic [WORD_W-1:0]        word_o,
  output logic signed [PROD_W-1:0] prod_o
);

  logic [WORD_W-1:0]        word_r;
  logic [WORD_W-1:0]        word_nxt;
  logic signed [PROD_W:0]   prod_full;
  logic signed [PROD_W-1:0] prod_r;

  // shift line: take the neighbor's word on each transaction
  assign word_nxt = ctl.shift ? word_i : word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  // weighted term of the word in use at the transaction
  assign prod_full = $signed({1'b0, word_r}) * WEIGHT;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
  end

  assign word_o = word_r;
  assign prod_o = prod_r;

endmodule

@@ sv/snsd_chan.sv @@
// One channel: generator cell, row of history cells, partial-sum stage and
// final add / floor / saturate stage. Depends on snsd_pkg, snsd_rng_cell, snsd_cell.
module snsd_chan import snsd_pkg::*; #(
  parameter logic [31:0] SEED = 32'h0000_0001
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  snsd_ctl_t               ctl,
  input  logic signed [IN_W-1:0]  sample,
  output logic signed [OUT_W-1:0] result
);

  localparam int NGRP = (HISTORY_TAPS + 1) / GROUP_N;

  logic [WORD_W-1:0]        word [HISTORY_TAPS];
  logic signed [PROD_W-1:0] prod [HISTORY_TAPS+1];
  logic [ZSUB_W-1:0]        zsub;

  logic signed [IN_W-1:0]   s1_r;
  logic signed [IN_W-1:0]   s2_r;
  logic signed [PSUM_W-1:0] psum_r [NGRP];
  logic signed [OUT_W-1:0]  res_r;

  logic signed [SUM_W-1:0]         total;
  logic signed [SUM_W-WORD_W-1:0]  dither;
  logic signed [IN_W:0]            mixed;
  logic signed [IN_W-FRAC_W:0]     floored;
  logic signed [OUT_W-1:0]         res_nxt;

  // generator at the head of the chain
  snsd_rng_cell #(.SEED(SEED)) u_rng (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .word_o (word[0]),
    .prod_o (prod[0]),
    .zsub_o (zsub)
  );

  // history cells, newest first
  for (genvar k = 1; k <= HISTORY_TAPS; k++) begin : g_cell
    if (k < HISTORY_TAPS) begin : g_mid
      snsd_cell #(.WEIGHT(TAP_WEIGHT[k])) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .word_i (word[k-1]),
        .word_o (word[k]),
        .prod_o (prod[k])
      );
    end else begin : g_last
      snsd_cell #(.WEIGHT(TAP_WEIGHT[k])) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .word_i (word[k-1]),
        .word_o (),
        .prod_o (prod[k])
      );
    end
  end

  // stage 1: sample, with an exact zero swapped for the generator substitute
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_r <= (sample == '0) ? $signed({{(IN_W-ZSUB_W){1'b0}}, zsub}) : sample;
    end
  end

  // stage 2: partial sums over groups of three terms
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s2_r <= s1_r;
      for (int g = 0; g < NGRP; g++) begin
        psum_r[g] <= PSUM_W'(prod[GROUP_N*g]) + PSUM_W'(prod[GROUP_N*g+1])
                   + PSUM_W'(prod[GROUP_N*g+2]);
      end
    end
  end

  // stage 3: total, floor shifts, saturate
  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + SUM_W'(psum_r[g]);
    end
    dither  = total[SUM_W-1:WORD_W];
    mixed   = (IN_W+1)'(s2_r) + (IN_W+1)'(dither);
    floored = mixed[IN_W:FRAC_W];
    if (floored > (IN_W-FRAC_W+1)'(OUT_MAX)) begin
      res_nxt = OUT_MAX;
    end else if (floored < (IN_W-FRAC_W+1)'(OUT_MIN)) begin
      res_nxt = OUT_MIN;
    end else begin
      res_nxt = floored[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

@@ sv/stereo_noise_shaped_dither_24bit_top.sv @@
// Stereo noise-shaped dither to 24 bits, one stereo frame per transaction.
// Input channel in_ch carries two 41-bit samples (16 fraction bits below the
// 24-bit LSB); result channel out_ch carries two saturated 24-bit samples.
// Both use valid/ready; a transaction completes when both are high.
// Each frame goes through the term, partial-sum and result registers in turn.
// Throughput: one frame per cycle; the three-stage pipeline (weighted terms,
// partial sums, final add and saturate) and the cell row all step together.
// Stall: while a result waits with out_ch.ready low the whole pipeline holds
// and in_ch.ready drops; frames already in flight are kept, none are lost.
// Bubbles are not squeezed out: input waits while a result is held, even
// with empty stages ahead of it.
// Reset (rst_n low, synchronous): generators load their seeds, history cells
// clear to zero, the pipeline empties; no clearing pass is needed.
// Depends on snsd_pkg, snsd_if, snsd_chan.
module stereo_noise_shaped_dither_24bit_top import snsd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  snsd_in_if.sink   in_ch,
  snsd_out_if.source out_ch
);

  logic      v1_r, v2_r, v3_r;
  logic      en;
  snsd_ctl_t ctl;

  // pipeline moves unless a result is held by the receiver
  assign en        = !v3_r || out_ch.ready;
  assign ctl.en    = en;
  assign ctl.shift = in_ch.valid && en;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= ctl.shift;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  snsd_chan #(.SEED(SEED_LEFT)) u_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.left_sample),
    .result (out_ch.left_out)
  );

  snsd_chan #(.SEED(SEED_RIGHT)) u_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_ch.right_sample),
    .result (out_ch.right_out)
  );

  assign out_ch.valid = v3_r;

endmodule
